[rtl/spq_pkg.sv]
package spq_pkg;

  // Default sizes of the queue
  localparam int unsigned DefDepth         = 16;
  localparam int unsigned DefPriorityWidth = 16;
  localparam int unsigned DefTagWidth      = 32;

  // Operation codes carried by opcode_i
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the operation of an accepted transfer
    logic apply;  // update the entry cells and the result registers
  } spq_cmd_t;

endpackage

[rtl/spq_ctrl.sv]
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output spq_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_e;

  state_e state_q, state_d;

  // Accept in idle, then apply the operation in the work state
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WORK;
        end
      end
      ST_WORK: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_WORK);

endmodule

[rtl/spq_dpath.sv]
module spq_dpath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH          = DefDepth,
  parameter int unsigned PRIORITY_WIDTH = DefPriorityWidth,
  parameter int unsigned TAG_WIDTH      = DefTagWidth,
  localparam int unsigned CntW          = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_cmd_t                  cmd_i,
  input  logic [1:0]                opcode_i,
  input  logic [PRIORITY_WIDTH-1:0] priority_req_i,
  input  logic [TAG_WIDTH-1:0]      tag_i,
  output logic                      valid_o,
  output logic [PRIORITY_WIDTH-1:0] head_priority_o,
  output logic [TAG_WIDTH-1:0]      head_tag_o,
  output logic [CntW-1:0]           count_o,
  output logic                      empty_res_o,
  output logic                      error_o
);

  // Captured operation
  logic [1:0]                op_q;
  logic [PRIORITY_WIDTH-1:0] prio_q;
  logic [TAG_WIDTH-1:0]      tag_q;

  // Entry cells, slot 0 is the head
  logic [PRIORITY_WIDTH-1:0] cell_prio_q [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio_d [DEPTH];
  logic [TAG_WIDTH-1:0]      cell_tag_q  [DEPTH];
  logic [TAG_WIDTH-1:0]      cell_tag_d  [DEPTH];

  logic [CntW-1:0] count_q, count_d;
  logic            full, err;
  logic [DEPTH-1:0] goes;

  // Result registers
  logic                      res_valid_q;
  logic [PRIORITY_WIDTH-1:0] res_prio_q, res_prio_d;
  logic [TAG_WIDTH-1:0]      res_tag_q, res_tag_d;
  logic [CntW-1:0]           res_cnt_q;
  logic                      res_empty_q, res_err_q;

  assign full = (count_q == CntW'(DEPTH));

  // Mark every cell at or behind the insert point: empty or lower priority
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      goes[i] = (CntW'(i) >= count_q) || (cell_prio_q[i] < prio_q);
    end
  end

  // Compare-and-shift step over all cells
  always_comb begin
    err     = 1'b0;
    count_d = count_q;
    for (int i = 0; i < DEPTH; i++) begin
      cell_prio_d[i] = cell_prio_q[i];
      cell_tag_d[i]  = cell_tag_q[i];
    end
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          err = 1'b1;
        end else begin
          count_d = count_q + CntW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (i > 0 && goes[(i > 0) ? i - 1 : 0]) begin
              cell_prio_d[i] = cell_prio_q[(i > 0) ? i - 1 : 0];
              cell_tag_d[i]  = cell_tag_q[(i > 0) ? i - 1 : 0];
            end else if (goes[i]) begin
              cell_prio_d[i] = prio_q;
              cell_tag_d[i]  = tag_q;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (count_q == '0) begin
          err = 1'b1;
        end else begin
          count_d = count_q - CntW'(1);
          for (int i = 0; i < DEPTH - 1; i++) begin
            cell_prio_d[i] = cell_prio_q[i + 1];
            cell_tag_d[i]  = cell_tag_q[i + 1];
          end
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Report zeros for the head of an empty queue
  always_comb begin
    if (count_d == '0) begin
      res_prio_d = '0;
      res_tag_d  = '0;
    end else begin
      res_prio_d = cell_prio_d[0];
      res_tag_d  = cell_tag_d[0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.apply;
      if (cmd_i.apply) begin
        count_q <= count_d;
      end
    end
  end

  // Payload: operation, cells and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      prio_q <= priority_req_i;
      tag_q  <= tag_i;
    end
    if (cmd_i.apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_prio_q[i] <= cell_prio_d[i];
        cell_tag_q[i]  <= cell_tag_d[i];
      end
      res_prio_q  <= res_prio_d;
      res_tag_q   <= res_tag_d;
      res_cnt_q   <= count_d;
      res_empty_q <= (count_d == '0);
      res_err_q   <= err;
    end
  end

  assign valid_o         = res_valid_q;
  assign head_priority_o = res_prio_q;
  assign head_tag_o      = res_tag_q;
  assign count_o         = res_cnt_q;
  assign empty_res_o     = res_empty_q;
  assign error_o         = res_err_q;

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue of up to DEPTH entries (priority, tag). A transfer is
// taken when start_i is high and busy_o is low; opcode_i selects insert,
// remove head or clear (code 3 only reports status). Each operation is accepted
// in the idle state and applied in the work state: a row of compare-and-shift
// cells finds the insert point and moves every entry at once. The result is
// registered there and appears in the next cycle, with valid_o high for exactly
// one cycle; it is not held, so the receiver must take it then and cannot stall
// the queue. A new operation may be started in the cycle the previous result is
// shown, but not while busy_o is high. Equal priorities leave in arrival order;
// the head reads as zero when the queue is empty, and error_o flags a remove on
// an empty queue or an insert into a full one, which change nothing.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH          = DefDepth,
  parameter int unsigned PRIORITY_WIDTH = DefPriorityWidth,
  parameter int unsigned TAG_WIDTH      = DefTagWidth,
  localparam int unsigned CntW          = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [PRIORITY_WIDTH-1:0] priority_req_i,
  input  logic [TAG_WIDTH-1:0]      tag_i,
  output logic                      valid_o,
  output logic [PRIORITY_WIDTH-1:0] head_priority_o,
  output logic [TAG_WIDTH-1:0]      head_tag_o,
  output logic [CntW-1:0]           count_o,
  output logic                      empty_res_o,
  output logic                      error_o
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  spq_dpath #(
    .DEPTH          (DEPTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .TAG_WIDTH      (TAG_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .opcode_i        (opcode_i),
    .priority_req_i  (priority_req_i),
    .tag_i           (tag_i),
    .valid_o         (valid_o),
    .head_priority_o (head_priority_o),
    .head_tag_o      (head_tag_o),
    .count_o         (count_o),
    .empty_res_o     (empty_res_o),
    .error_o         (error_o)
  );

endmodule

[tb/tb_sorted_priority_queue.sv]
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned CntW       = $clog2(DefDepth + 1);
  localparam int unsigned NumOps     = 1450;
  localparam int unsigned PhaseLen   = 480;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  // Code 3 is not an operation: the queue only reports its status
  localparam logic [1:0]  OP_STATUS  = 2'd3;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic [DefPriorityWidth-1:0] prio;
    logic [DefTagWidth-1:0]      tag;
  } queue_cmd_t;

  typedef struct {
    queue_cmd_t  cmd;
    int unsigned idle_pct;
    bit          drain_first;
  } cmd_slot_t;

  typedef struct packed {
    logic [DefPriorityWidth-1:0] head_priority;
    logic [DefTagWidth-1:0]      head_tag;
    logic [CntW-1:0]             count;
    logic                        empty_res;
    logic                        error;
  } head_status_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        start_i        = 1'b0;
  logic [1:0]                  opcode_i       = OP_STATUS;
  logic [DefPriorityWidth-1:0] priority_req_i = '0;
  logic [DefTagWidth-1:0]      tag_i          = '0;
  logic                        busy_o;
  logic                        valid_o;
  logic [DefPriorityWidth-1:0] head_priority_o;
  logic [DefTagWidth-1:0]      head_tag_o;
  logic [CntW-1:0]             count_o;
  logic                        empty_res_o;
  logic                        error_o;

  cmd_slot_t    op_backlog[$];
  head_status_t pending_status[$];
  cmd_slot_t    cur_op;
  bit           holding;
  bit           took_now;
  bit           hold_off;
  int           sent_cnt = 0;
  int           got_cnt  = 0;
  int           fail_cnt = 0;
  int unsigned  cycle_cnt = 0;

  // Shadow copy of the queue contents
  logic [DefPriorityWidth-1:0] shadow_prio[DefDepth];
  logic [DefTagWidth-1:0]      shadow_tag[DefDepth];
  int unsigned                 shadow_cnt = 0;

  // Coverage tallies for the summary
  int unsigned n_insert = 0, n_remove = 0, n_clear = 0, n_status = 0;
  int unsigned n_full_err = 0, n_empty_err = 0, n_full_seen = 0;

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .priority_req_i (priority_req_i),
    .tag_i          (tag_i),
    .valid_o        (valid_o),
    .head_priority_o(head_priority_o),
    .head_tag_o     (head_tag_o),
    .count_o        (count_o),
    .empty_res_o    (empty_res_o),
    .error_o        (error_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow queue and return the status it reports
  function automatic head_status_t apply_shadow_op(queue_cmd_t cmd);
    head_status_t st;
    int unsigned  pos;
    st = '0;
    case (cmd.opcode)
      OP_INSERT: begin
        n_insert++;
        if (shadow_cnt >= DefDepth) begin
          st.error = 1'b1;
          n_full_err++;
        end else begin
          // insert ahead of the first strictly lower priority
          pos = shadow_cnt;
          for (int i = 0; i < int'(shadow_cnt); i++) begin
            if (shadow_prio[i] < cmd.prio) begin
              pos = i;
              break;
            end
          end
          for (int i = int'(shadow_cnt); i > int'(pos); i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_tag[i]  = shadow_tag[i-1];
          end
          shadow_prio[pos] = cmd.prio;
          shadow_tag[pos]  = cmd.tag;
          shadow_cnt++;
          if (shadow_cnt == DefDepth) n_full_seen++;
        end
      end
      OP_REMOVE: begin
        n_remove++;
        if (shadow_cnt == 0) begin
          st.error = 1'b1;
          n_empty_err++;
        end else begin
          for (int i = 0; i + 1 < int'(shadow_cnt); i++) begin
            shadow_prio[i] = shadow_prio[i+1];
            shadow_tag[i]  = shadow_tag[i+1];
          end
          shadow_cnt--;
        end
      end
      OP_CLEAR: begin
        n_clear++;
        shadow_cnt = 0;
      end
      default: n_status++;
    endcase
    if (shadow_cnt != 0) begin
      st.head_priority = shadow_prio[0];
      st.head_tag      = shadow_tag[0];
    end
    st.count     = shadow_cnt[CntW-1:0];
    st.empty_res = (shadow_cnt == 0);
    return st;
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= MaxReports) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  // Append one operation; the idle rate and drain points follow its position
  function automatic void add_op(logic [1:0] opcode, logic [DefPriorityWidth-1:0] prio,
                                 logic [DefTagWidth-1:0] tag);
    cmd_slot_t   slot;
    int unsigned idx;
    idx              = op_backlog.size();
    slot.cmd.opcode  = opcode;
    slot.cmd.prio    = prio;
    slot.cmd.tag     = tag;
    slot.idle_pct    = (idx < PhaseLen) ? 28 : (idx < 2 * PhaseLen) ? 61 : 0;
    slot.drain_first = (idx == 25) || (idx % 240 == 120);
    op_backlog.push_back(slot);
  endfunction

  // Favor a few small values so that equal priorities are common
  function automatic logic [DefPriorityWidth-1:0] pick_priority();
    case ($urandom_range(0, 9))
      6, 7:    return DefPriorityWidth'($urandom);
      8:       return '1;
      9:       return DefPriorityWidth'(16'h8000 + $urandom_range(0, 3));
      default: return DefPriorityWidth'($urandom_range(0, 5));
    endcase
  endfunction

  // Driver: present the next operation and predict its status on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      holding = 1'b0;
    end else begin
      took_now = start_i && !busy_o;
      if (took_now) begin
        pending_status.push_back(apply_shadow_op(cur_op.cmd));
        sent_cnt <= sent_cnt + 1;
        holding = 1'b0;
      end
      if (!holding && op_backlog.size() != 0) begin
        hold_off = (op_backlog[0].drain_first && (took_now || sent_cnt != got_cnt)) ||
                   ($urandom_range(0, 99) < op_backlog[0].idle_pct);
        if (!hold_off) begin
          cur_op = op_backlog.pop_front();
          holding = 1'b1;
          opcode_i       <= cur_op.cmd.opcode;
          priority_req_i <= cur_op.cmd.prio;
          tag_i          <= cur_op.cmd.tag;
        end
      end
      start_i <= holding;
    end
  end

  // Monitor: check each status strobe against the oldest prediction
  always @(posedge clk_i) begin
    head_status_t seen;
    head_status_t want;
    if (rst_ni && valid_o) begin
      seen = {head_priority_o, head_tag_o, count_o, empty_res_o, error_o};
      if (got_cnt == sent_cnt) begin
        note_failure($sformatf("unexpected status: head %h/%h count %0d empty %b err %b",
                               seen.head_priority, seen.head_tag, seen.count,
                               seen.empty_res, seen.error));
      end else begin
        want = pending_status.pop_front();
        got_cnt <= got_cnt + 1;
        if (seen.head_priority !== want.head_priority || seen.head_tag !== want.head_tag ||
            seen.count !== want.count || seen.empty_res !== want.empty_res ||
            seen.error !== want.error) begin
          note_failure($sformatf(
            "status mismatch: exp head %h/%h count %0d empty %b err %b, got %h/%h %0d %b %b",
            want.head_priority, want.head_tag, want.count, want.empty_res, want.error,
            seen.head_priority, seen.head_tag, seen.count, seen.empty_res, seen.error));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d transfers outstanding",
               cycle_cnt, sent_cnt - got_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned burst_len;
    int unsigned mode;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned rem_pct;

    // Directed: empty-queue corner cases
    add_op(OP_REMOVE, '0, '0);
    add_op(OP_CLEAR, '0, '0);
    add_op(OP_STATUS, '0, '0);
    // Extremes of priority and tag, then a run of equal priorities
    add_op(OP_INSERT, '0, '0);
    add_op(OP_INSERT, '1, '1);
    add_op(OP_INSERT, 16'h8000, 32'h0000_0001);
    add_op(OP_INSERT, 16'h8000, 32'h0000_0002);
    add_op(OP_INSERT, 16'h8000, 32'h0000_0003);
    add_op(OP_REMOVE, '0, '0);
    // Fill to the brim, then push a top priority into the full queue
    for (int i = 0; i < 12; i++) add_op(OP_INSERT, pick_priority(), $urandom);
    add_op(OP_INSERT, '1, 32'hA5A5_5A5A);
    add_op(OP_STATUS, '1, '1);
    add_op(OP_CLEAR, '0, '0);
    add_op(OP_REMOVE, '0, '0);

    // Random bursts: fill, drain or mixed, with rare clears and status reads
    while (op_backlog.size() < NumOps) begin
      burst_len = $urandom_range(4, 40);
      mode      = $urandom_range(0, 3);
      ins_pct   = (mode == 0) ? 85 : (mode == 1) ? 10 : 50;
      rem_pct   = (mode == 0) ? 10 : (mode == 1) ? 85 : 45;
      for (int i = 0; i < int'(burst_len) && op_backlog.size() < NumOps; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
          add_op(OP_INSERT, pick_priority(), $urandom);
        else if (roll < ins_pct + rem_pct)
          add_op(OP_REMOVE, DefPriorityWidth'($urandom), $urandom);
        else if (roll < ins_pct + rem_pct + 2)
          add_op(OP_CLEAR, DefPriorityWidth'($urandom), $urandom);
        else
          add_op(OP_STATUS, DefPriorityWidth'($urandom), $urandom);
      end
    end

    // Hold reset, then release it on a rising edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transfer and its status, then let the pipeline settle
    while (op_backlog.size() != 0 || start_i || got_cnt != sent_cnt) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_status.size() != 0)
      note_failure($sformatf("%0d status results never arrived", pending_status.size()));

    $display("Checked %0d operations: %0d inserts, %0d removes, %0d clears, %0d status reads",
             got_cnt, n_insert, n_remove, n_clear, n_status);
    $display("Queue reached full %0d times; %0d full-insert and %0d empty-remove errors, %0d fails",
             n_full_seen, n_full_err, n_empty_err, fail_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
